// ===== design/ars_pkg.sv =====
// shared types and constants for the access relay sequencer
package ars_pkg;

  // phase codes
  localparam logic [1:0] PH_SLEEP     = 2'd0;
  localparam logic [1:0] PH_WAIT      = 2'd1;
  localparam logic [1:0] PH_WAIT_AUTH = 2'd2;
  localparam logic [1:0] PH_AUTH      = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_BLINK_PERIOD     = 3'd0;
  localparam logic [2:0] REG_POLL_PERIOD      = 3'd1;
  localparam logic [2:0] REG_REQUEST_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_GRANT_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_PULSE_LENGTH     = 3'd4;
  localparam logic [2:0] REG_HIGHEST_VALID_ID = 3'd5;

  // register reset values
  localparam logic [15:0] BLINK_PERIOD_RST     = 16'd500;
  localparam logic [15:0] POLL_PERIOD_RST      = 16'd100;
  localparam logic [15:0] REQUEST_TIMEOUT_RST  = 16'd15000;
  localparam logic [15:0] GRANT_TIMEOUT_RST    = 16'd35000;
  localparam logic [15:0] PULSE_LENGTH_RST     = 16'd500;
  localparam logic [7:0]  HIGHEST_VALID_ID_RST = 8'd20;

  localparam int ADDR_WIDTH = 5;

  // one tick item
  typedef struct packed {
    logic       wake;
    logic       button_rose;
    logic       finger_present;
    logic [7:0] match_id;
  } tick_t;

  // one result item
  typedef struct packed {
    logic       relay_on;
    logic       button_lamp;
    logic       sensor_lamp;
    logic [1:0] phase_out;
    logic       poll_strobe;
  } result_t;

  // configuration register set
  typedef struct packed {
    logic [15:0] blink_period;
    logic [15:0] poll_period;
    logic [15:0] request_timeout;
    logic [15:0] grant_timeout;
    logic [15:0] pulse_length;
    logic [7:0]  highest_valid_id;
  } cfg_t;

endpackage

// ===== design/ars_regs.sv =====
// configuration register bank behind the apb-style port
module ars_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ars_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output ars_pkg::cfg_t                   cfg
);

  logic       wr_en;
  logic [2:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_period     <= ars_pkg::BLINK_PERIOD_RST;
      cfg.poll_period      <= ars_pkg::POLL_PERIOD_RST;
      cfg.request_timeout  <= ars_pkg::REQUEST_TIMEOUT_RST;
      cfg.grant_timeout    <= ars_pkg::GRANT_TIMEOUT_RST;
      cfg.pulse_length     <= ars_pkg::PULSE_LENGTH_RST;
      cfg.highest_valid_id <= ars_pkg::HIGHEST_VALID_ID_RST;
    end else if (wr_en) begin
      case (index)
        ars_pkg::REG_BLINK_PERIOD:     cfg.blink_period     <= pwdata[15:0];
        ars_pkg::REG_POLL_PERIOD:      cfg.poll_period      <= pwdata[15:0];
        ars_pkg::REG_REQUEST_TIMEOUT:  cfg.request_timeout  <= pwdata[15:0];
        ars_pkg::REG_GRANT_TIMEOUT:    cfg.grant_timeout    <= pwdata[15:0];
        ars_pkg::REG_PULSE_LENGTH:     cfg.pulse_length     <= pwdata[15:0];
        ars_pkg::REG_HIGHEST_VALID_ID: cfg.highest_valid_id <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (index)
      ars_pkg::REG_BLINK_PERIOD:     prdata = {16'd0, cfg.blink_period};
      ars_pkg::REG_POLL_PERIOD:      prdata = {16'd0, cfg.poll_period};
      ars_pkg::REG_REQUEST_TIMEOUT:  prdata = {16'd0, cfg.request_timeout};
      ars_pkg::REG_GRANT_TIMEOUT:    prdata = {16'd0, cfg.grant_timeout};
      ars_pkg::REG_PULSE_LENGTH:     prdata = {16'd0, cfg.pulse_length};
      ars_pkg::REG_HIGHEST_VALID_ID: prdata = {24'd0, cfg.highest_valid_id};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/ars_core.sv =====
// sequencer state and the single-pass next-state and result logic
module ars_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  ars_pkg::cfg_t    cfg,
  input  ars_pkg::tick_t   item,
  output ars_pkg::result_t result
);

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};
  localparam logic [TIMER_WIDTH-1:0] TZERO = '0;

  logic [1:0]             phase, phase_next;
  logic [TIMER_WIDTH-1:0] request_elapsed, request_elapsed_next;
  logic [TIMER_WIDTH-1:0] blink_elapsed, blink_elapsed_next;
  logic [TIMER_WIDTH-1:0] poll_elapsed, poll_elapsed_next;
  logic [TIMER_WIDTH-1:0] grant_elapsed, grant_elapsed_next;
  logic [TIMER_WIDTH-1:0] pulse_elapsed, pulse_elapsed_next;
  logic                   lamp_state, lamp_state_next;
  logic                   relay_state, relay_state_next;
  logic                   sensor_lamp_state, sensor_lamp_state_next;
  logic                   strobe;
  logic                   granted;

  // saturating counter step
  function automatic logic [TIMER_WIDTH-1:0] bump(input logic [TIMER_WIDTH-1:0] c);
    return (c == TMAX) ? c : c + TIMER_WIDTH'(1);
  endfunction

  // counter reached a 16-bit register value
  function automatic logic reached(input logic [TIMER_WIDTH-1:0] c, input logic [15:0] lim);
    return CW'(c) >= CW'(lim);
  endfunction

  // next state for one tick
  always_comb begin
    request_elapsed_next   = bump(request_elapsed);
    blink_elapsed_next     = bump(blink_elapsed);
    poll_elapsed_next      = bump(poll_elapsed);
    grant_elapsed_next     = bump(grant_elapsed);
    pulse_elapsed_next     = bump(pulse_elapsed);
    phase_next             = phase;
    lamp_state_next        = lamp_state;
    relay_state_next       = relay_state;
    sensor_lamp_state_next = sensor_lamp_state;
    strobe                 = 1'b0;
    granted                = 1'b0;

    case (phase)
      ars_pkg::PH_SLEEP: begin
        if (item.wake) phase_next = ars_pkg::PH_WAIT;
      end
      ars_pkg::PH_WAIT: begin
        if (item.button_rose) begin
          sensor_lamp_state_next = 1'b1;
          request_elapsed_next   = TZERO;
          blink_elapsed_next     = TZERO;
          poll_elapsed_next      = TZERO;
          phase_next             = ars_pkg::PH_WAIT_AUTH;
        end
      end
      ars_pkg::PH_WAIT_AUTH: begin
        // lamp blink
        if (reached(blink_elapsed_next, cfg.blink_period)) begin
          blink_elapsed_next = TZERO;
          lamp_state_next    = ~lamp_state;
        end
        // finger check
        if (reached(poll_elapsed_next, cfg.poll_period)) begin
          poll_elapsed_next = TZERO;
          strobe            = 1'b1;
          if (item.finger_present) begin
            lamp_state_next = 1'b1;
            if (item.match_id <= cfg.highest_valid_id) begin
              granted                = 1'b1;
              pulse_elapsed_next     = TZERO;
              relay_state_next       = 1'b1;
              sensor_lamp_state_next = 1'b0;
              grant_elapsed_next     = TZERO;
              phase_next             = ars_pkg::PH_AUTH;
            end
          end
        end
        // request timeout, a grant on the same tick wins
        if (!granted && reached(request_elapsed_next, cfg.request_timeout)) begin
          lamp_state_next        = 1'b0;
          relay_state_next       = 1'b0;
          sensor_lamp_state_next = 1'b0;
          phase_next             = ars_pkg::PH_SLEEP;
        end
      end
      default: begin
        // authorized: timeout, relay retrigger or end of relay pulse
        if (reached(grant_elapsed_next, cfg.grant_timeout)) begin
          lamp_state_next        = 1'b0;
          relay_state_next       = 1'b0;
          sensor_lamp_state_next = 1'b0;
          phase_next             = ars_pkg::PH_SLEEP;
        end else if (item.button_rose) begin
          pulse_elapsed_next = TZERO;
          relay_state_next   = 1'b1;
        end
        if (reached(pulse_elapsed_next, cfg.pulse_length)) relay_state_next = 1'b0;
      end
    endcase
  end

  // result of this tick
  always_comb begin
    result.relay_on    = relay_state_next;
    result.button_lamp = lamp_state_next;
    result.sensor_lamp = sensor_lamp_state_next;
    result.phase_out   = phase_next;
    result.poll_strobe = strobe;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= ars_pkg::PH_SLEEP;
      request_elapsed   <= TZERO;
      blink_elapsed     <= TZERO;
      poll_elapsed      <= TZERO;
      grant_elapsed     <= TZERO;
      pulse_elapsed     <= TZERO;
      lamp_state        <= 1'b0;
      relay_state       <= 1'b0;
      sensor_lamp_state <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      request_elapsed   <= request_elapsed_next;
      blink_elapsed     <= blink_elapsed_next;
      poll_elapsed      <= poll_elapsed_next;
      grant_elapsed     <= grant_elapsed_next;
      pulse_elapsed     <= pulse_elapsed_next;
      lamp_state        <= lamp_state_next;
      relay_state       <= relay_state_next;
      sensor_lamp_state <= sensor_lamp_state_next;
    end
  end

endmodule

// ===== design/access_relay_sequencer.sv =====
// top level of the access relay sequencer: tick register, core, result register, config port
//
// Each tick item is one millisecond of the door controller: it steps five saturating
// timers, moves through sleep, wait button, wait authorization and authorized, and yields
// exactly one result item with the relay, lamp, phase and poll strobe outputs. The block
// takes one tick item per clock cycle unless results stall. An item is captured in the tick
// register, goes through the sequencer logic in one pass and lands in the result register; a
// stalled result register holds back one more item in the tick register before ready drops.
// Configuration is written through the apb-style port (registers at byte address 4*index);
// the user must write it only while no item is in flight; the block does not enforce it.
module access_relay_sequencer #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick_valid,
  output logic                           tick_ready,
  input  ars_pkg::tick_t                 tick,
  output logic                           result_valid,
  input  logic                           result_ready,
  output ars_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ars_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  ars_pkg::cfg_t    cfg;
  ars_pkg::tick_t   tick_r;
  ars_pkg::result_t core_result;
  logic             tick_full;
  logic             advance;

  // configuration registers
  ars_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer state and step logic
  ars_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cfg    (cfg),
    .item   (tick_r),
    .result (core_result)
  );

  // pipeline flow control
  assign advance    = tick_full && (!result_valid || result_ready);
  assign tick_ready = !tick_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_full    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (tick_ready) tick_full <= tick_valid;
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) tick_r <= tick;
    if (advance) result <= core_result;
  end

`ifndef SYNTHESIS
  // relay only closes in the authorized phase
  a_relay_auth: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.relay_on) |-> (result.phase_out == ars_pkg::PH_AUTH))
    else $error("relay closed outside authorized phase");

  // sensor backlight only while waiting for authorization
  a_sensor_wait: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.sensor_lamp) |-> (result.phase_out == ars_pkg::PH_WAIT_AUTH))
    else $error("sensor lamp lit outside wait authorization");

  // sleep means every drive is off
  a_sleep_dark: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.phase_out == ars_pkg::PH_SLEEP))
      |-> (!result.relay_on && !result.button_lamp && !result.sensor_lamp))
    else $error("output drive active in sleep");
`endif

endmodule
